// ===== design/preemptive_lifo_task_scheduler_macros.svh =====
// Assertion helpers shared by the scheduler RTL.
`ifndef PREEMPTIVE_LIFO_TASK_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_LIFO_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PLTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define PLTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");

`endif

// ===== design/plts_pkg.sv =====
package plts_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);

	localparam int ID_W   = 8;
	localparam int TIME_W = 11;
	localparam int DUR_W  = 10;
	localparam int STAT_W = 2;

	// stream payload widths
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 8;

	// request kinds (s_tuser)
	localparam logic REQ_ARRIVAL = 1'b0;
	localparam logic REQ_FLUSH   = 1'b1;

	// result status codes (m_tuser)
	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_ACCEPT  = 2'd1;
	localparam logic [STAT_W-1:0] ST_DROPPED = 2'd2;
	localparam logic [STAT_W-1:0] ST_FLUSHED = 2'd3;

endpackage

// ===== design/preemptive_lifo_task_scheduler.sv =====
// Channel | Dir | Handshake          | tdata                            | tuser    | tlast
// --------+-----+--------------------+----------------------------------+----------+------
// request | in  | s_tvalid s_tready  | task_id, start_minute, duration  | req_type | -
// result  | out | m_tvalid m_tready  | done_id                          | status   | last
//
// One request at a time. A request is accepted in IDLE and acknowledged in ACK; a spend or a flush
// inserts one step per popped task plus one closing step that trims the top task or finds the
// time or the stack used up.
// Reset (arst_n low, asynchronous) empties the stack, zeroes the clock and drops any pending
// result; stack entries are not cleared, as only entries below the count are read.
// A stalled result port (m_tready low) holds the sequencer on any step that emits.
module preemptive_lifo_task_scheduler (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [7:0] task_id, [18:8] start_minute, [28:19] duration, [31:29] zero
	input  logic [plts_pkg::S_TDATA_W-1:0]   s_tdata,
	// [0] req_type
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [7:0] done_id
	output logic [plts_pkg::M_TDATA_W-1:0]   m_tdata,
	// [1:0] status
	output logic [plts_pkg::STAT_W-1:0]      m_tuser,
	output logic                             m_tlast
);
	import plts_pkg::*;

	typedef enum logic [1:0] {IDLE, SPEND, DRAIN, ACK} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TIME_W-1:0]   cur_q;
	logic [TIME_W-1:0]   elapsed_q;
	logic                req_q;
	logic [ID_W-1:0]     id_q;
	logic [DUR_W-1:0]    dur_q;

	logic                m_tvalid_q;
	logic [ID_W-1:0]     m_id_q;
	logic [STAT_W-1:0]   m_stat_q;
	logic                m_last_q;

	// stack storage, bottom first
	logic [ID_W-1:0]     ids_q [STACK_DEPTH];
	logic [DUR_W-1:0]    rem_q [STACK_DEPTH];

	logic [ID_W-1:0]     in_id;
	logic [TIME_W-1:0]   in_start;
	logic [DUR_W-1:0]    in_dur;
	logic                accept;
	logic                out_free;
	logic                emit;
	logic [CNT_W-1:0]    cnt_dec;
	logic [IDX_W-1:0]    top_idx;
	logic [IDX_W-1:0]    push_idx;
	logic                full;
	logic [ID_W-1:0]     top_id;
	logic [DUR_W-1:0]    top_rem;
	logic [TIME_W:0]     diff;
	logic [TIME_W:0]     neg_diff;
	logic                borrow;

	// stack write port
	logic                wr_rem_en;
	logic                wr_id_en;
	logic [IDX_W-1:0]    wr_idx;
	logic [DUR_W-1:0]    wr_rem;

	assign in_id    = s_tdata[ID_W-1:0];
	assign in_start = s_tdata[ID_W+TIME_W-1:ID_W];
	assign in_dur   = s_tdata[ID_W+TIME_W+DUR_W-1:ID_W+TIME_W];

	assign s_tready = (state_q == IDLE);
	assign accept   = s_tvalid && s_tready;
	// a result slot is free when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;

	assign cnt_dec  = cnt_q - CNT_W'(1);
	assign top_idx  = cnt_dec[IDX_W-1:0];
	assign push_idx = cnt_q[IDX_W-1:0];
	assign full     = (cnt_q == CNT_W'(STACK_DEPTH));
	assign top_id   = ids_q[top_idx];
	assign top_rem  = rem_q[top_idx];

	// shared subtractor: time left to spend minus the top task's remaining work
	assign diff     = {1'b0, elapsed_q} - {{(TIME_W + 1 - DUR_W){1'b0}}, top_rem};
	assign neg_diff = (TIME_W + 1)'(0) - diff;
	assign borrow   = diff[TIME_W];

	// a result goes out this cycle: a pop while spending or flushing, or the acknowledgement
	assign emit = out_free && ((state_q == SPEND && elapsed_q != '0 && cnt_q != '0 && !borrow)
		|| (state_q == DRAIN && cnt_q != '0) || state_q == ACK);

	always_comb begin
		wr_rem_en = 1'b0;
		wr_id_en  = 1'b0;
		wr_idx    = top_idx;
		wr_rem    = neg_diff[DUR_W-1:0];
		unique case (state_q)
			SPEND: begin
				// top task outlives the elapsed time: shrink its remaining work
				if (elapsed_q != '0 && cnt_q != '0 && borrow)
					wr_rem_en = 1'b1;
			end
			ACK: begin
				if (req_q == REQ_ARRIVAL && !full && out_free) begin
					wr_rem_en = 1'b1;
					wr_id_en  = 1'b1;
					wr_idx    = push_idx;
					wr_rem    = dur_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_rem_en)
			rem_q[wr_idx] <= wr_rem;
		if (wr_id_en)
			ids_q[wr_idx] <= id_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			cnt_q      <= '0;
			cur_q      <= '0;
			elapsed_q  <= '0;
			req_q      <= REQ_ARRIVAL;
			id_q       <= '0;
			dur_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_id_q     <= '0;
			m_stat_q   <= ST_DONE;
			m_last_q   <= 1'b0;
		end else begin
			// show a new result, or retire the shown one once taken
			if (emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				IDLE: begin
					if (accept) begin
						req_q <= s_tuser;
						id_q  <= in_id;
						dur_q <= in_dur;
						if (s_tuser == REQ_FLUSH) begin
							state_q <= DRAIN;
						end else if (in_start > cur_q) begin
							// spend the gap since the previous arrival
							elapsed_q <= in_start - cur_q;
							cur_q     <= in_start;
							state_q   <= SPEND;
						end else begin
							// start at or before the clock: nothing to spend
							state_q <= ACK;
						end
					end
				end
				SPEND: begin
					if (elapsed_q == '0 || cnt_q == '0) begin
						state_q <= ACK;
					end else if (borrow) begin
						// top task absorbs the rest; its new remaining work is written above
						elapsed_q <= '0;
						state_q   <= ACK;
					end else if (out_free) begin
						// top task completes: pop, report, carry the leftover time down
						elapsed_q  <= diff[TIME_W-1:0];
						cnt_q      <= cnt_dec;
						m_id_q     <= top_id;
						m_stat_q   <= ST_DONE;
						m_last_q   <= 1'b0;
					end
				end
				DRAIN: begin
					if (cnt_q == '0) begin
						state_q <= ACK;
					end else if (out_free) begin
						cnt_q      <= cnt_dec;
						m_id_q     <= top_id;
						m_stat_q   <= ST_DONE;
						m_last_q   <= 1'b0;
					end
				end
				ACK: begin
					if (out_free) begin
						m_id_q     <= id_q;
						m_last_q   <= 1'b1;
						state_q    <= IDLE;
						if (req_q == REQ_FLUSH) begin
							m_stat_q <= ST_FLUSHED;
							cnt_q    <= '0;
							cur_q    <= '0;
						end else if (full) begin
							m_stat_q <= ST_DROPPED;
						end else begin
							// push the new task on top; storage written above
							m_stat_q <= ST_ACCEPT;
							cnt_q    <= cnt_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_id_q;
	assign m_tuser  = m_stat_q;
	assign m_tlast  = m_last_q;

`include "preemptive_lifo_task_scheduler_macros.svh"

	`PLTS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(STACK_DEPTH))
	`PLTS_ASSERT_NOW(a_last_is_ack, m_tvalid, m_tlast == (m_tuser != ST_DONE))
	`PLTS_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready)
	`PLTS_ASSERT_NEXT(a_flush_clears, state_q == ACK && req_q == REQ_FLUSH && out_free,
		cnt_q == '0 && cur_q == '0)

endmodule
